/* rtl/tpac_pkg.sv */
// ----------------------------------------------------------------------------
// tpac_pkg
// Shared types and codes for the two-point ADC temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpac_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TEMP_LOW  = 2'd0,
		REG_TEMP_HIGH = 2'd1,
		REG_CODE_LOW  = 2'd2,
		REG_CODE_HIGH = 2'd3
	} reg_idx_t;

	// Conversion direction.
	localparam logic OP_CODE_TO_DEG = 1'b0;
	localparam logic OP_DEG_TO_CODE = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTRW  = 2;

	typedef struct packed {
		logic [31:0] slope;
		logic [31:0] offset;
		logic        rdy;
	} coeff_t;

	typedef struct packed {
		logic        op;
		logic        err;
		logic [31:0] num;
		logic [31:0] div;
	} q_entry_t;

	function automatic logic [31:0] asr1(input logic [31:0] v);
		return {v[31], v[31:1]};
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

/* rtl/tpac_coef.sv */
// ----------------------------------------------------------------------------
// tpac_coef
// Holds the calibration registers and derives slope and offset with a
// serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpac_coef import tpac_pkg::*; #(
	parameter logic [31:0] SCALE = 32'd256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	output coeff_t           coeff
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_SUB  = 5'b10000
	} st_t;

	st_t         state_q;
	logic [15:0] tl_q, th_q, cl_q, ch_q;
	logic [31:0] dq_q, mb_q, rem_q, slope_q, offset_q, tls_q;
	logic        neg_q, zero_q;
	logic [4:0]  cnt_q;

	logic [15:0] span16;
	logic [31:0] span, num;
	logic [32:0] trial;
	logic        take;

	assign span16 = ch_q - cl_q;
	assign span   = sext16(span16);
	assign num    = (sext16(th_q) - sext16(tl_q)) * SCALE + asr1(span);
	assign trial  = {rem_q, dq_q[31]};
	assign take   = trial >= {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			tl_q    <= 16'd0;
			th_q    <= 16'd1000;
			cl_q    <= 16'd0;
			ch_q    <= 16'd1000;
			cnt_q   <= 5'd0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_addr))
					REG_TEMP_LOW:  tl_q <= cfg_wdata;
					REG_TEMP_HIGH: th_q <= cfg_wdata;
					REG_CODE_LOW:  cl_q <= cfg_wdata;
					REG_CODE_HIGH: ch_q <= cfg_wdata;
					default: ;
				endcase
				state_q <= ST_LOAD;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_LOAD: begin
						state_q <= ST_DIV;
						cnt_q   <= 5'd0;
					end
					ST_DIV: begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'd31) begin
							state_q <= ST_MUL;
						end
					end
					ST_MUL:  state_q <= ST_SUB;
					ST_SUB:  state_q <= ST_IDLE;
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				dq_q   <= num[31] ? (32'd0 - num) : num;
				mb_q   <= span[31] ? (32'd0 - span) : span;
				neg_q  <= num[31] ^ span[31];
				zero_q <= (span16 == 16'd0);
				rem_q  <= 32'd0;
			end
			ST_DIV: begin
				rem_q <= take ? 32'(trial - {1'b0, mb_q}) : trial[31:0];
				dq_q  <= {dq_q[30:0], take};
			end
			ST_MUL: begin
				if (zero_q) begin
					slope_q <= 32'd0;
				end else begin
					slope_q <= neg_q ? (32'd0 - dq_q) : dq_q;
				end
				tls_q <= sext16(tl_q) * SCALE;
			end
			ST_SUB:  offset_q <= tls_q - {16'd0, cl_q} * slope_q;
			default: ;
		endcase
	end

	assign coeff.slope  = slope_q;
	assign coeff.offset = offset_q;
	assign coeff.rdy    = (state_q == ST_IDLE) && !cfg_we;

endmodule

`default_nettype wire

/* rtl/tpac_front.sv */
// ----------------------------------------------------------------------------
// tpac_front
// Accepts items, forms the dividend and divisor, flags a zero slope on degrees-to-code items.
// ----------------------------------------------------------------------------
`default_nettype none

module tpac_front import tpac_pkg::*; #(
	parameter logic [31:0] SCALE = 32'd256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire coeff_t      coeff,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [15:0] raw_code,
	input  wire logic [15:0] degrees_in,
	output logic             push,
	output q_entry_t         entry,
	input  wire logic        q_full
);

	logic        v_s1, op_s1;
	logic [31:0] prod_s1, ma, mb;
	logic        adv;

	assign adv      = !v_s1 || !q_full;
	assign in_ready = coeff.rdy && adv;
	assign ma       = (op == OP_DEG_TO_CODE) ? sext16(degrees_in) : {16'd0, raw_code};
	assign mb       = (op == OP_DEG_TO_CODE) ? SCALE : coeff.slope;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			prod_s1 <= ma * mb;
		end
	end

	assign push      = v_s1 && !q_full;
	assign entry.op  = op_s1;
	assign entry.err = (op_s1 == OP_DEG_TO_CODE) && (coeff.slope == 32'd0);
	assign entry.num = (op_s1 == OP_DEG_TO_CODE)
		? prod_s1 - coeff.offset + asr1(coeff.slope)
		: prod_s1 + coeff.offset + (SCALE >> 1);
	assign entry.div = (op_s1 == OP_DEG_TO_CODE) ? coeff.slope : SCALE;

endmodule

`default_nettype wire

/* rtl/tpac_queue.sv */
// ----------------------------------------------------------------------------
// tpac_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpac_queue import tpac_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t wr,
	input  wire logic     pop,
	output q_entry_t      rd,
	output logic          full,
	output logic          empty,
	output logic [QPTRW:0] count
);

	q_entry_t         mem_q [QDEPTH];
	logic [QPTRW-1:0] wp_q, rp_q;
	logic [QPTRW:0]   cnt_q;
	logic             do_pop;

	assign full   = (cnt_q == (QPTRW+1)'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rd     = mem_q[rp_q];
	assign count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTRW+1)'(push) - (QPTRW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr;
	end

endmodule

`default_nettype wire

/* rtl/tpac_back.sv */
// ----------------------------------------------------------------------------
// tpac_back
// Pipelined signed divider, one quotient bit per stage, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpac_back import tpac_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire q_entry_t    q_rd,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      degrees_out,
	output logic [15:0]      code_out,
	output logic             divide_error
);

	localparam int NST = 32;

	logic        en;
	logic        v_s   [NST+1];
	logic        op_s  [NST+1];
	logic        err_s [NST+1];
	logic        neg_s [NST+1];
	logic [31:0] dq_s  [NST+1];
	logic [31:0] rem_s [NST+1];
	logic [31:0] div_s [NST+1];

	logic        o_valid_q, o_err_q;
	logic [15:0] o_deg_q, o_code_q;
	logic [31:0] qf;

	assign en  = !o_valid_q || out_ready;
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0]  <= q_rd.op;
			err_s[0] <= q_rd.err;
			neg_s[0] <= q_rd.num[31] ^ q_rd.div[31];
			dq_s[0]  <= q_rd.num[31] ? (32'd0 - q_rd.num) : q_rd.num;
			div_s[0] <= q_rd.div[31] ? (32'd0 - q_rd.div) : q_rd.div;
			rem_s[0] <= 32'd0;
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_stage
		logic [32:0] trial;
		logic        take;
		assign trial = {rem_s[i], dq_s[i][31]};
		assign take  = trial >= {1'b0, div_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[i+1]  <= op_s[i];
				err_s[i+1] <= err_s[i];
				neg_s[i+1] <= neg_s[i];
				div_s[i+1] <= div_s[i];
				rem_s[i+1] <= take ? 32'(trial - {1'b0, div_s[i]}) : trial[31:0];
				dq_s[i+1]  <= {dq_s[i][30:0], take};
			end
		end
	end

	assign qf = neg_s[NST] ? (32'd0 - dq_s[NST]) : dq_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (en) begin
			o_valid_q <= v_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_err_q  <= err_s[NST];
			o_deg_q  <= (op_s[NST] == OP_CODE_TO_DEG) ? qf[15:0] : 16'd0;
			o_code_q <= (op_s[NST] == OP_DEG_TO_CODE && !err_s[NST]) ? qf[15:0] : 16'd0;
		end
	end

	assign out_valid    = o_valid_q;
	assign degrees_out  = o_deg_q;
	assign code_out     = o_code_q;
	assign divide_error = o_err_q;

endmodule

`default_nettype wire

/* rtl/two_point_adc_temperature_convert.sv */
// ----------------------------------------------------------------------------
// two_point_adc_temperature_convert
// Two-point linear calibration between ADC codes and degrees.
//
// Channel    Dir  Fields (low bit up)
// s_axis     in   tdata: raw_code[15:0], degrees_in[31:16]; tuser: opcode
// m_axis     out  tdata: degrees_out[15:0], code_out[31:16]; tuser: divide_error
// cfg        in   cfg_we, cfg_addr (register index), cfg_wdata
//
// One item per clock is accepted while the coefficients are ready and the
// queue has room; a result passes the multiply register, queue, sign stage,
// 32 divider stages and output register.
// After reset and after every register write the slope divider runs
// serially and s_axis_tready stays low until the new coefficients are ready.
// A stall on m_axis freezes the divider; the queue then absorbs the front.
// ----------------------------------------------------------------------------
`default_nettype none

module two_point_adc_temperature_convert import tpac_pkg::*; #(
	parameter int COEFF_SCALE_FACTOR = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // raw_code, degrees_in
	input  wire logic        s_axis_tuser,   // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // degrees_out, code_out
	output logic             m_axis_tuser    // divide_error
);

	localparam logic [31:0] SCALE = 32'(COEFF_SCALE_FACTOR);

	coeff_t         coeff;
	q_entry_t       q_wr, q_rd;
	logic           push, pop, q_full, q_empty;
	logic [QPTRW:0] q_count;

	tpac_coef #(.SCALE(SCALE)) u_coef (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_wdata, .coeff
	);

	tpac_front #(.SCALE(SCALE)) u_front (
		.clk, .arst_n, .coeff,
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tuser),
		.raw_code   (s_axis_tdata[15:0]),
		.degrees_in (s_axis_tdata[31:16]),
		.push, .entry(q_wr), .q_full
	);

	tpac_queue u_queue (
		.clk, .arst_n, .push, .wr(q_wr), .pop, .rd(q_rd),
		.full(q_full), .empty(q_empty), .count(q_count)
	);

	tpac_back u_back (
		.clk, .arst_n, .q_empty, .q_rd, .pop,
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.degrees_out  (m_axis_tdata[15:0]),
		.code_out     (m_axis_tdata[31:16]),
		.divide_error (m_axis_tuser)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
		else $error("divide error with nonzero result");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> coeff.rdy)
		else $error("item accepted during coefficient update");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= (QPTRW+1)'(QDEPTH))
		else $error("queue overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full queue");

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the two-point ADC temperature converter. A directed
// table, then random traffic across several calibration settings; every
// result is checked field by field against a local calibration model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import tpac_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCALE = 256;

	typedef struct packed {
		logic [15:0] deg;
		logic [15:0] code;
		logic        err;
	} conv_res_t;

	typedef struct {
		logic        op;
		logic [15:0] raw;
		logic [15:0] deg;
		logic        known;
		conv_res_t   res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	// Calibration registers and the coefficients derived from them.
	logic [15:0] cal_regs [4];
	logic [31:0] slope_q, offset_q;

	conv_res_t expected_q [$];
	int        mismatches;
	stim_row_t table_rows [$];

	two_point_adc_temperature_convert i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic void derive_line();
		logic [31:0] span, dtemp;
		logic [15:0] diff;
		diff = cal_regs[REG_CODE_HIGH] - cal_regs[REG_CODE_LOW];
		span = {{16{diff[15]}}, diff};
		dtemp = {{16{cal_regs[REG_TEMP_HIGH][15]}}, cal_regs[REG_TEMP_HIGH]}
			- {{16{cal_regs[REG_TEMP_LOW][15]}}, cal_regs[REG_TEMP_LOW]};
		if (span == 0)
			slope_q = 0;
		else
			slope_q = div_trunc(dtemp * SCALE + {span[31], span[31:1]}, span);
		offset_q = {{16{cal_regs[REG_TEMP_LOW][15]}}, cal_regs[REG_TEMP_LOW]} * SCALE
			- {16'd0, cal_regs[REG_CODE_LOW]} * slope_q;
	endfunction

	function automatic conv_res_t convert(logic op, logic [15:0] raw, logic [15:0] deg);
		conv_res_t r;
		logic [31:0] num;
		logic [31:0] q;
		r = '0;
		if (op == OP_CODE_TO_DEG) begin
			num = {16'd0, raw} * slope_q + offset_q + SCALE / 2;
			q = div_trunc(num, SCALE);
			r.deg = q[15:0];
		end else if (slope_q == 0) begin
			r.err = 1'b1;
		end else begin
			num = {{16{deg[15]}}, deg} * SCALE - offset_q + {slope_q[31], slope_q[31:1]};
			q = div_trunc(num, slope_q);
			r.code = q[15:0];
		end
		return r;
	endfunction

	task automatic write_cal(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		cal_regs[idx] = val;
		derive_line();
	endtask

	task automatic set_line(logic [15:0] tl, logic [15:0] th, logic [15:0] cl,
			logic [15:0] ch);
		write_cal(REG_TEMP_LOW, tl);
		write_cal(REG_TEMP_HIGH, th);
		write_cal(REG_CODE_LOW, cl);
		write_cal(REG_CODE_HIGH, ch);
	endtask

	// Waits until every result is back, then lets the pipeline drain.
	task automatic drain();
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (45) @(negedge clk);
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_item(logic op, logic [15:0] raw, logic [15:0] deg,
			logic known, conv_res_t res);
		conv_res_t pred;
		int        g;
		pred = convert(op, raw, deg);
		if (known && pred !== res) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row: typed %h, computed %h", res, pred);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {deg, raw};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_q.push_back(pred);
		@(negedge clk);
		g = gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic send_random(int count);
		logic [15:0] raw, deg;
		for (int i = 0; i < count; i++) begin
			raw = 16'($urandom);
			deg = 16'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				raw = 16'(cal_regs[REG_CODE_LOW] + $urandom_range(0, 8) - 4);
				deg = 16'(cal_regs[REG_TEMP_HIGH] + $urandom_range(0, 8) - 4);
			end
			send_item(1'($urandom_range(0, 1)), raw, deg, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		conv_res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.deg = m_axis_tdata[15:0];
			got.code = m_axis_tdata[31:16];
			got.err = m_axis_tuser;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: deg %h code %h err %b",
						got.deg, got.code, got.err);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: deg %h/%h code %h/%h err %b/%b (exp/act)",
							want.deg, got.deg, want.code, got.code, want.err, got.err);
				end
			end
		end
	end

	// Receiver stalls, mostly short; while directed rows remain, every cycle
	// that draws no new stall raises tready again.
	always @(negedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 99) < 8)
			m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 99) < 60 || table_rows.size() != 0)
			m_axis_tready <= 1'b1;
	end

	function automatic void add_row(logic op, logic [15:0] raw, logic [15:0] deg,
			logic known, logic [15:0] d, logic [15:0] c, logic e);
		stim_row_t r;
		r.op = op; r.raw = raw; r.deg = deg; r.known = known;
		r.res = '{deg: d, code: c, err: e};
		table_rows.push_back(r);
	endfunction

	initial begin
		#2000000;
		$display("[two_point_adc_temperature_convert] ERROR");
		$finish;
	end

	initial begin
		stim_row_t r;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		mismatches = 0;
		cal_regs[REG_TEMP_LOW] = 16'd0;
		cal_regs[REG_TEMP_HIGH] = 16'd1000;
		cal_regs[REG_CODE_LOW] = 16'd0;
		cal_regs[REG_CODE_HIGH] = 16'd1000;
		derive_line();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset the line is the identity: slope 256, offset 0.
		add_row(OP_CODE_TO_DEG, 16'd0, 16'd0, 1, 16'd0, 16'd0, 0);
		add_row(OP_CODE_TO_DEG, 16'd500, 16'd0, 1, 16'd500, 16'd0, 0);
		add_row(OP_CODE_TO_DEG, 16'hFFFF, 16'd0, 1, 16'hFFFF, 16'd0, 0);
		add_row(OP_DEG_TO_CODE, 16'd0, 16'd0, 1, 16'd0, 16'd0, 0);
		add_row(OP_DEG_TO_CODE, 16'd0, 16'd123, 1, 16'd0, 16'd123, 0);
		add_row(OP_DEG_TO_CODE, 16'hFFFF, 16'h7FFF, 1, 16'd0, 16'h7FFF, 0);
		add_row(OP_DEG_TO_CODE, 16'h1234, 16'h8000, 1, 16'd0, 16'h8001, 0);
		add_row(OP_CODE_TO_DEG, 16'h8000, 16'hFFFF, 0, 0, 0, 0);
		add_row(OP_DEG_TO_CODE, 16'h0001, 16'hFFFF, 0, 0, 0, 0);
		while (table_rows.size() != 0) begin
			r = table_rows.pop_front();
			send_item(r.op, r.raw, r.deg, r.known, r.res);
		end
		s_axis_tvalid <= 1'b0;
		drain();

		// Zero span: code to degrees still works, degrees to code flags an error.
		set_line(16'd25, 16'd100, 16'd700, 16'd700);
		send_item(OP_DEG_TO_CODE, 16'd0, 16'd50, 1, '{deg: 0, code: 0, err: 1});
		send_item(OP_CODE_TO_DEG, 16'd3, 16'd0, 0, '0);
		send_random(40);
		drain();

		// Extremes, including a negative slope and large slopes that wrap.
		set_line(16'h8000, 16'h7FFF, 16'd0, 16'd1);
		send_random(80);
		drain();
		set_line(16'h7FFF, 16'h8000, 16'hFFFF, 16'd0);
		send_random(80);
		drain();
		set_line(16'd0, 16'd0, 16'd100, 16'd5000);
		send_random(60);
		drain();

		for (int k = 0; k < 5; k++) begin
			set_line(16'($urandom_range(0, 200) - 50), 16'($urandom_range(50, 1500)),
				16'($urandom_range(0, 4000)), 16'($urandom_range(4000, 65535)));
			if (k == 3)
				set_line(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			send_random(80);
			drain();
		end

		if (mismatches == 0 && expected_q.size() == 0)
			$display("[two_point_adc_temperature_convert] OK");
		else
			$display("[two_point_adc_temperature_convert] ERROR");
		$finish;
	end
endmodule

`default_nettype wire

/* sim.f */
rtl/tpac_pkg.sv
rtl/tpac_coef.sv
rtl/tpac_front.sv
rtl/tpac_queue.sv
rtl/tpac_back.sv
rtl/two_point_adc_temperature_convert.sv
test/tb.sv
